[design/assert_macros.svh]
// Assertion helpers shared by the RTL; clock and reset are clk / rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition in one cycle that implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sss_pkg.sv]
package sss_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SWP_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_PRESENT   = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_member;
    logic [4:0]         count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } out_item_t;

  // Update strobes broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_cmd_t;

  // Running min/max handed from cell to cell toward cell 0
  typedef struct packed {
    logic               valid;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } carry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DONE
  } state_t;

endpackage

[design/sss_cell.sv]
module sss_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sss_pkg::cell_cmd_t cmd,
  input  logic signed [31:0] key,
  input  logic               prev_valid,
  input  logic               prev_hit,
  input  logic               next_valid,
  input  logic signed [31:0] next_entry,
  input  sss_pkg::carry_t    next_carry,
  output logic               valid,
  output logic signed [31:0] entry,
  output logic               hit,
  output sss_pkg::carry_t    carry
);

  logic               valid_r;
  logic signed [31:0] entry_r;
  sss_pkg::carry_t    carry_r, carry_nxt;
  logic               match;
  logic               first_empty;

  // Match against the key; hit marks this cell or any earlier one matched
  assign match       = valid_r && (entry_r == key);
  assign hit         = prev_hit || match;
  assign first_empty = !valid_r && prev_valid;

  // Entry storage: remove pulls from the right neighbor, insert fills the first hole
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.rem_en && hit) begin
      valid_r <= next_valid;
    end else if (cmd.ins_en && first_empty) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rem_en && hit) begin
      entry_r <= next_entry;
    end else if (cmd.ins_en && first_empty) begin
      entry_r <= key;
    end
  end

  // Fold own entry into the neighbor's min/max
  always_comb begin
    carry_nxt = next_carry;
    if (valid_r) begin
      carry_nxt.valid = 1'b1;
      if (!next_carry.valid) begin
        carry_nxt.min_value = entry_r;
        carry_nxt.max_value = entry_r;
      end else begin
        if (entry_r < next_carry.min_value) carry_nxt.min_value = entry_r;
        if (entry_r > next_carry.max_value) carry_nxt.max_value = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.valid <= 1'b0;
    end else begin
      carry_r.valid <= carry_nxt.valid;
    end
    carry_r.min_value <= carry_nxt.min_value;
    carry_r.max_value <= carry_nxt.max_value;
  end

  assign valid = valid_r;
  assign entry = entry_r;
  assign carry = carry_r;

endmodule

[design/small_set_store_core.sv]
// Channel | Direction | Handshake            | Beat
// in_     | input     | in_valid / in_ready  | sss_pkg::in_item_t  (func, value)
// out_    | output    | out_valid / out_ready| sss_pkg::out_item_t (status .. max_value)
//
// Each item passes through accept, a lookup/update state (S_EXEC), then a sweep state
// (S_SWEEP) while min/max ripples through the cell chain one cell per cycle, then the
// result beat, plus any output stall.
// One item is in flight at a time; in_ready is low until the result beat is taken.
// Synchronous active-low reset empties the store; entry data is not cleared.
`include "assert_macros.svh"

module small_set_store_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  localparam int CAP = sss_pkg::CAPACITY;

  sss_pkg::state_t          state_r, state_nxt;
  sss_pkg::in_item_t        req_r;
  logic [sss_pkg::SWP_W-1:0] cnt_r;
  logic [sss_pkg::CNT_W-1:0] held_r;
  logic [1:0]               status_r, status_nxt;
  logic                     member_r, member_nxt;
  sss_pkg::cell_cmd_t       cmd;
  logic                     found, full, exec;

  logic [CAP-1:0]           valid_vec;
  logic [CAP:0]             hit_chain;
  logic signed [31:0]       entry_arr [CAP];
  sss_pkg::carry_t          carry_arr [CAP];

  // Cell chain: cell 0 holds the oldest entry, min/max flows toward cell 0
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic               p_valid, n_valid;
    logic signed [31:0] n_entry;
    sss_pkg::carry_t    n_carry;

    if (i == 0) begin : g_first
      assign p_valid = 1'b1;
    end else begin : g_mid
      assign p_valid = valid_vec[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_entry = 32'sd0;
      assign n_carry = '0;
    end else begin : g_next
      assign n_valid = valid_vec[i+1];
      assign n_entry = entry_arr[i+1];
      assign n_carry = carry_arr[i+1];
    end

    sss_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .key        (req_r.value),
      .prev_valid (p_valid),
      .prev_hit   (hit_chain[i]),
      .next_valid (n_valid),
      .next_entry (n_entry),
      .next_carry (n_carry),
      .valid      (valid_vec[i]),
      .entry      (entry_arr[i]),
      .hit        (hit_chain[i+1]),
      .carry      (carry_arr[i])
    );
  end

  assign found = hit_chain[CAP];
  assign full  = valid_vec[CAP-1];
  assign exec  = (state_r == sss_pkg::S_EXEC);

  // Operation decode: status, membership afterward and cell strobes
  always_comb begin
    status_nxt = sss_pkg::ST_DONE;
    member_nxt = found;
    cmd        = '0;
    unique case (req_r.func)
      sss_pkg::FUNC_INSERT: begin
        if (found) begin
          status_nxt = sss_pkg::ST_PRESENT;
        end else if (full) begin
          status_nxt = sss_pkg::ST_FULL;
        end else begin
          member_nxt = 1'b1;
          cmd.ins_en = exec;
        end
      end
      sss_pkg::FUNC_REMOVE: begin
        member_nxt = 1'b0;
        if (found) begin
          cmd.rem_en = exec;
        end else begin
          status_nxt = sss_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = found ? sss_pkg::ST_DONE : sss_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sss_pkg::S_IDLE:  if (in_valid) state_nxt = sss_pkg::S_EXEC;
      sss_pkg::S_EXEC:  state_nxt = sss_pkg::S_SWEEP;
      sss_pkg::S_SWEEP: if (cnt_r == sss_pkg::SWP_W'(CAP - 1)) state_nxt = sss_pkg::S_DONE;
      sss_pkg::S_DONE:  if (out_ready) state_nxt = sss_pkg::S_IDLE;
      default:          state_nxt = sss_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sss_pkg::S_IDLE: in_ready  = 1'b1;
      sss_pkg::S_DONE: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::S_IDLE;
      held_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cmd.ins_en) begin
        held_r <= held_r + sss_pkg::CNT_W'(1);
      end else if (cmd.rem_en) begin
        held_r <= held_r - sss_pkg::CNT_W'(1);
      end
      if (state_r == sss_pkg::S_SWEEP) begin
        cnt_r <= cnt_r + sss_pkg::SWP_W'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // Request and per-item result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (exec) begin
      status_r <= status_nxt;
      member_r <= member_nxt;
    end
  end

  // Result beat; min/max settle in cell 0 by the end of the sweep
  always_comb begin
    out_data.status    = status_r;
    out_data.is_member = member_r;
    out_data.count     = 5'(held_r);
    out_data.min_value = carry_arr[0].valid ? carry_arr[0].min_value : 32'sd0;
    out_data.max_value = carry_arr[0].valid ? carry_arr[0].max_value : 32'sd0;
  end

  // Checks
  `ASSERT_ALWAYS(a_prefix_count, ($countones(valid_vec) == held_r),
                 "cell valid bits disagree with held count")
  `ASSERT_ALWAYS(a_one_in_flight, (!(in_ready && out_valid)),
                 "input taken while a result is pending")
  `ASSERT_NEXT(a_remove_shrinks, (cmd.rem_en),
               (held_r == $past(held_r) - sss_pkg::CNT_W'(1)),
               "remove did not decrement held count")
  `ASSERT_NEXT(a_insert_grows, (cmd.ins_en),
               (held_r == $past(held_r) + sss_pkg::CNT_W'(1)),
               "insert did not increment held count")

endmodule

[tb/sv/tb_small_set_store_core.sv]
`timescale 1ns / 100ps

module tb_small_set_store_core;

  // func 3 has no operation of its own; the block treats it as a lookup
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int RAND_ITEMS   = 1250;
  localparam int POOL_N       = 20;
  localparam int LONG_HOLD    = 240;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 60;

  // Shadow copy of the set plus the replies still owed by the block
  class set_tracker;
    logic signed [31:0]  held_vals[$];
    sss_pkg::out_item_t  replies_due[$];
    int                  fail_count;

    function new();
      fail_count = 0;
    endfunction

    function int slot_of(logic signed [31:0] v);
      foreach (held_vals[i]) begin
        if (held_vals[i] == v) return i;
      end
      return -1;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Apply one accepted op to the shadow set and queue the reply it owes
    function void apply_op(sss_pkg::in_item_t beat);
      int                 pos;
      logic [1:0]         st;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      sss_pkg::out_item_t rep;
      pos = slot_of(beat.value);
      case (beat.func)
        sss_pkg::FUNC_INSERT: begin
          // duplicate check wins over the full check
          if (pos >= 0) st = sss_pkg::ST_PRESENT;
          else if (held_vals.size() >= sss_pkg::CAPACITY) st = sss_pkg::ST_FULL;
          else begin
            held_vals.push_back(beat.value);
            st = sss_pkg::ST_DONE;
          end
        end
        sss_pkg::FUNC_REMOVE: begin
          if (pos < 0) st = sss_pkg::ST_NOT_FOUND;
          else begin
            held_vals.delete(pos);
            st = sss_pkg::ST_DONE;
          end
        end
        // plain lookup and the spare code
        default: st = (pos >= 0) ? sss_pkg::ST_DONE : sss_pkg::ST_NOT_FOUND;
      endcase
      // min/max read zero on an empty set
      lo = '0;
      hi = '0;
      foreach (held_vals[i]) begin
        if (i == 0 || held_vals[i] < lo) lo = held_vals[i];
        if (i == 0 || held_vals[i] > hi) hi = held_vals[i];
      end
      rep.status    = st;
      rep.is_member = (slot_of(beat.value) >= 0);
      rep.count     = 5'(held_vals.size());
      rep.min_value = lo;
      rep.max_value = hi;
      replies_due.push_back(rep);
    endfunction

    task report(string msg);
      if (fail_count < PRINT_CAP) $display("%0t MISMATCH: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_reply(sss_pkg::out_item_t got);
      sss_pkg::out_item_t want;
      if (replies_due.size() == 0) begin
        report("result beat with no operation outstanding");
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.is_member !== want.is_member)
        report($sformatf("is_member got %0b want %0b", got.is_member, want.is_member));
      if (got.count !== want.count)
        report($sformatf("count got %0d want %0d", got.count, want.count));
      if (got.min_value !== want.min_value)
        report($sformatf("min_value got %0d want %0d",
                         $signed(got.min_value), $signed(want.min_value)));
      if (got.max_value !== want.max_value)
        report($sformatf("max_value got %0d want %0d",
                         $signed(got.max_value), $signed(want.max_value)));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  sss_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  sss_pkg::out_item_t out_data;

  set_tracker         sb;
  logic signed [31:0] pool [POOL_N];
  bit                 long_hold_req;
  int                 quiet_cycles;

  small_set_store_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Beat monitor: retire the reply first, then note a new op on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_reply(out_data);
      if (in_valid && in_ready) sb.apply_op(in_data);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic sss_pkg::in_item_t mk_beat(logic [1:0] f, logic signed [31:0] v);
    sss_pkg::in_item_t beat;
    beat.func  = f;
    beat.value = v;
    return beat;
  endfunction

  // Mostly values from a small pool so inserts collide, removes hit and the set fills
  function automatic sss_pkg::in_item_t make_item(bit filling);
    int                 r;
    logic [1:0]         f;
    logic signed [31:0] v;
    r = $urandom_range(0, 99);
    if (r < (filling ? 55 : 25)) f = sss_pkg::FUNC_INSERT;
    else if (r < (filling ? 72 : 65)) f = sss_pkg::FUNC_REMOVE;
    else if (r < 92) f = sss_pkg::FUNC_QUERY;
    else f = FUNC_SPARE;
    if ($urandom_range(0, 99) < 80) v = pool[$urandom_range(0, POOL_N - 1)];
    else v = $urandom;
    return mk_beat(f, v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task send_item(sss_pkg::in_item_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Receiver: stall profile changes every so often, plus one long hold-off on request
  initial begin
    int ready_pct;
    int span;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(15, 95);
      span      = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        if (long_hold_req && !hold_done) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          hold_done = 1'b1;
        end
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Sender
  initial begin
    int i;
    int k;
    int burst;
    int sent;
    bit fill_mode;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    long_hold_req = 1'b0;
    pool[0] = 32'sh7fffffff;
    pool[1] = 32'sh80000000;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    for (i = 4; i < 10; i++) pool[i] = int'($urandom_range(0, 8)) - 4;
    for (i = 10; i < POOL_N; i++) pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty set, extremes, duplicate, spare code, shifting remove, full set
    send_item(mk_beat(sss_pkg::FUNC_QUERY, 32'sd5));
    send_item(mk_beat(sss_pkg::FUNC_REMOVE, 32'sd5));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, 32'sh7fffffff));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, 32'sh80000000));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, 32'sd0));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, -32'sd1));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, 32'sh80000000));
    send_item(mk_beat(FUNC_SPARE, 32'sd0));
    send_item(mk_beat(FUNC_SPARE, 32'sd12345));
    send_item(mk_beat(sss_pkg::FUNC_REMOVE, 32'sd0));
    for (i = 1; i <= 13; i++) send_item(mk_beat(sss_pkg::FUNC_INSERT, i * 977 - 6000));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, 32'sd42));
    send_item(mk_beat(sss_pkg::FUNC_INSERT, -32'sd1));
    send_item(mk_beat(sss_pkg::FUNC_QUERY, -32'sd1));

    // Random: bursts and gaps, alternating fill and drain bias
    sent      = 0;
    fill_mode = 1'b1;
    while (sent < RAND_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      for (k = 0; k < burst && sent < RAND_ITEMS; k++) begin
        if (sent % 40 == 0) fill_mode = !fill_mode;
        // receiver backs off for a long stretch while we keep offering
        if (sent == 300) long_hold_req = 1'b1;
        // let the block drain completely once
        if (sent == 700) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (sb.pending() != 0) @(negedge clk);
        end
        send_item(make_item(fill_mode));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 24));
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/sss_pkg.sv
design/sss_cell.sv
design/small_set_store_core.sv
tb/sv/tb_small_set_store_core.sv
